>>> rtl/dfpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_pkg
// shared types and constants of the framed packet capture block
// ----------------------------------------------------------------------------
package dfpc_pkg;

  localparam logic [7:0] START_BYTE  = 8'h10;
  localparam logic [7:0] END_BYTE    = 8'h03;
  localparam logic [7:0] ID_REPORT   = 8'h8f;
  localparam logic [7:0] SUB_STATUS  = 8'hac;
  localparam logic [7:0] SUB_TIMING  = 8'hab;
  localparam logic [7:0] ID_SAT_LIST = 8'h6d;

  localparam int HEAD_DEPTH  = 19;
  localparam int HEAD_IDX_W  = $clog2(HEAD_DEPTH);
  localparam int STATUS_LEN  = 69;
  localparam int TIMING_LEN  = 18;
  localparam int SAT_MIN_LEN = 3;
  localparam int STATUS_ITEMS = 14;
  localparam int TIMING_ITEMS = 18;
  localparam int SAT_ITEMS    = 3;
  localparam int PAYLOAD_MAX  = 18;
  localparam int IDX_W        = 5;
  localparam int LEN_W        = 7;
  localparam int LEN_MAX      = 127;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_TIMING = 2'd2,
    KIND_SAT    = 2'd3
  } frame_kind_t;

  // one closed frame as handed from the front to the back
  typedef struct packed {
    frame_kind_t                   kind;
    logic [IDX_W-1:0]              last_idx;
    logic [LEN_W-1:0]              length;
    logic [PAYLOAD_MAX-1:0][7:0]   bytes;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

>>> rtl/dle_framed_packet_capture_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dle_framed_packet_capture_top
// byte-stuffed serial deframer that captures status, timing and satellite
// frames and emits their payload words at frame close
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   rx_byte, line_error, slot_busy
//  out_     output     out_valid/out_stall frame_kind, byte_index, data_byte,
//                                          frame_length, last
//
// one input word is taken per cycle; in_stall rises only while the
// descriptor queue (two closed frames) is full
// a closed frame yields 1 to 18 output words, one per cycle from the back while not stalled
// the result is registered in the descriptor queue and then in the output register
// out_stall holds the output register; the front keeps taking words meanwhile
// reset (rst_n low, synchronous) clears hunt, escape, count, queue and output
// valid; the head byte store is not cleared
//
module dle_framed_packet_capture_top import dfpc_pkg::*; #(
  parameter int BUFFER_BYTES = 69
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_line_error,
  input  logic [2:0]  in_slot_busy,
  // result word channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [4:0]  out_byte_index,
  output logic [7:0]  out_data_byte,
  output logic [6:0]  out_frame_length,
  output logic        out_last
);

  logic          in_accept;
  logic          push;
  logic          pop;
  frame_desc_t   close_desc;
  frame_desc_t   head_desc;
  queue_status_t q_status;

  // front only stalls when no room is left for a closing frame
  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  // front: hunt, unstuff, head store, classification
  dfpc_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .rx_byte    (in_rx_byte),
    .line_error (in_line_error),
    .slot_busy  (in_slot_busy),
    .push       (push),
    .desc       (close_desc)
  );

  // descriptor queue decouples byte intake from the output bursts
  dfpc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_desc (close_desc),
    .pop     (pop),
    .rd_desc (head_desc),
    .status  (q_status)
  );

  // back: one result word per cycle into the output register while not stalled
  dfpc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc             (head_desc),
    .q_status         (q_status),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_frame_kind   (out_frame_kind),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

endmodule

>>> rtl/dfpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_front
// hunts for frame start, unstuffs bytes, keeps the frame head and classifies
// each frame at close into a descriptor for the queue
// ----------------------------------------------------------------------------
module dfpc_front import dfpc_pkg::*; #(
  parameter int BUFFER_BYTES = 69
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          line_error,
  input  logic [2:0]    slot_busy,
  output logic          push,
  output frame_desc_t   desc
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  logic             hunting_r, hunting_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       head_r [HEAD_DEPTH];
  logic             head_we;
  logic             hunt_eff;
  logic [7:0]       cnt8;
  logic             is_status, is_timing, is_sat;

  assign hunt_eff = hunting_r | line_error;
  assign cnt8     = 8'(count_r);

  always_comb begin
    hunting_nxt = hunting_r;
    esc_nxt     = esc_r;
    count_nxt   = count_r;
    head_we     = 1'b0;
    push        = 1'b0;
    if (accept) begin
      if (hunt_eff) begin
        hunting_nxt = 1'b1;
        if (rx_byte == START_BYTE) begin
          hunting_nxt = 1'b0;
          esc_nxt     = 1'b0;
          count_nxt   = '0;
        end
      end else if (esc_r && rx_byte == END_BYTE) begin
        push        = 1'b1;
        hunting_nxt = 1'b1;
        esc_nxt     = 1'b0;
      end else if (!esc_r && rx_byte == START_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (count_r < CNT_W'(BUFFER_BYTES)) begin
          head_we   = (cnt8 < 8'(HEAD_DEPTH));
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      esc_r     <= 1'b0;
      count_r   <= '0;
    end else begin
      hunting_r <= hunting_nxt;
      esc_r     <= esc_nxt;
      count_r   <= count_nxt;
    end
  end

  // head store, no reset: a timing frame reads its last entry as an earlier
  // frame left it
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[count_r[HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

  // classification at close
  assign is_status = (cnt8 == 8'(STATUS_LEN)) && (head_r[0] == ID_REPORT) &&
                     (head_r[1] == SUB_STATUS) && !slot_busy[0];
  assign is_timing = (cnt8 == 8'(TIMING_LEN)) && (head_r[0] == ID_REPORT) &&
                     (head_r[1] == SUB_TIMING) && !slot_busy[1];
  assign is_sat    = (cnt8 >= 8'(SAT_MIN_LEN)) && (head_r[0] == ID_SAT_LIST) &&
                     !slot_busy[2];

  always_comb begin
    desc.length = (cnt8 > 8'(LEN_MAX)) ? LEN_W'(LEN_MAX) : cnt8[LEN_W-1:0];
    desc.kind     = KIND_NONE;
    desc.last_idx = '0;
    desc.bytes    = '0;
    if (is_status) begin
      desc.kind     = KIND_STATUS;
      desc.last_idx = IDX_W'(STATUS_ITEMS - 1);
      for (int i = 0; i < PAYLOAD_MAX; i++) begin
        desc.bytes[i] = head_r[i+1];
      end
    end else if (is_timing) begin
      desc.kind     = KIND_TIMING;
      desc.last_idx = IDX_W'(TIMING_ITEMS - 1);
      for (int i = 0; i < PAYLOAD_MAX; i++) begin
        desc.bytes[i] = head_r[i+1];
      end
    end else if (is_sat) begin
      desc.kind     = KIND_SAT;
      desc.last_idx = IDX_W'(SAT_ITEMS - 1);
      for (int i = 0; i < SAT_ITEMS; i++) begin
        desc.bytes[i] = head_r[i];
      end
    end
  end

endmodule

>>> rtl/dfpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_queue
// short queue of closed frame descriptors between front and back
// ----------------------------------------------------------------------------
module dfpc_queue import dfpc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  frame_desc_t    wr_desc,
  input  logic           pop,
  output frame_desc_t    rd_desc,
  output queue_status_t  status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_desc_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.valid = (count_r != '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign rd_desc      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

>>> rtl/dfpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpc_back
// walks the head descriptor item by item into the output register
// ----------------------------------------------------------------------------
module dfpc_back import dfpc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  frame_desc_t    desc,
  input  queue_status_t  q_status,
  output logic           pop,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [1:0]     out_frame_kind,
  output logic [4:0]     out_byte_index,
  output logic [7:0]     out_data_byte,
  output logic [6:0]     out_frame_length,
  output logic           out_last
);

  logic             valid_r, valid_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             load, at_last;

  logic [1:0]       kind_r;
  logic [IDX_W-1:0] index_r;
  logic [7:0]       data_r;
  logic [LEN_W-1:0] len_r;
  logic             last_r;

  assign load    = q_status.valid && (!valid_r || !out_stall);
  assign at_last = (idx_r == desc.last_idx);
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = at_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= 2'(desc.kind);
      index_r <= idx_r;
      data_r  <= desc.bytes[idx_r];
      len_r   <= desc.length;
      last_r  <= at_last;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_kind   = kind_r;
  assign out_byte_index   = index_r;
  assign out_data_byte    = data_r;
  assign out_frame_length = len_r;
  assign out_last         = last_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte-stuffed frame capture block: a queue-fed
// driver offers received words, a behavioral deframer predicts the capture
// words of every closed frame, and a monitor compares each output word in
// order while both sides idle and stall at random
// ----------------------------------------------------------------------------
module tb;
  import dfpc_pkg::*;

  localparam int BUF_BYTES      = 69;
  localparam int MAX_IDLE       = 11;    // per-word idle draw, both sides
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving
  localparam int TOTAL_WORDS    = 450;   // input word budget for the whole run
  localparam int HOLD_FRAMES    = 8;
  localparam int TAIL_CYCLES    = 50;

  localparam logic [2:0] SLOTS_FREE  = 3'b000;
  localparam logic [2:0] SLOT_STATUS = 3'b001;
  localparam logic [2:0] SLOT_TIMING = 3'b010;
  localparam logic [2:0] SLOT_SAT    = 3'b100;

  // one received word as offered on the input channel
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
    logic [2:0] slot_busy;
  } rx_word_t;

  // one capture word as expected on the output channel
  typedef struct packed {
    frame_kind_t kind;
    logic [4:0]  byte_idx;
    logic [7:0]  data;
    logic [6:0]  length;
    logic        last;
  } capture_word_t;

  typedef logic [7:0] body_q_t[$];

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  // block inputs, all known from time zero
  logic       in_valid      = 1'b0;
  logic [7:0] in_rx_byte    = 8'h00;
  logic       in_line_error = 1'b0;
  logic [2:0] in_slot_busy  = 3'b000;
  logic       out_stall     = 1'b0;

  // block outputs
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_frame_kind;
  logic [4:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic [6:0] out_frame_length;
  logic       out_last;

  dle_framed_packet_capture_top #(
    .BUFFER_BYTES (BUF_BYTES)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_line_error    (in_line_error),
    .in_slot_busy     (in_slot_busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_kind   (out_frame_kind),
    .out_byte_index   (out_byte_index),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  // words waiting to be offered, and capture words waiting to come out
  rx_word_t      rx_words_pending[$];
  capture_word_t capture_words_due[$];

  int mismatches   = 0;
  int hold_reqs    = 0;   // bumped by the stimulus to ask for a long hold-off
  int holds_taken  = 0;
  int words_pushed = 0;

  // --------------------------------------------------------------------------
  // deframer state, mirrors the block after reset
  // --------------------------------------------------------------------------
  logic       hunt_st   = 1'b1;
  logic       escape_st = 1'b0;
  int         stored_st = 0;
  logic [7:0] head_mem [HEAD_DEPTH];

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // frame close: classify on the head bytes and queue the capture words
  task automatic queue_capture(logic [2:0] busy);
    frame_kind_t   kind;
    int            first;
    int            n;
    int            len;
    capture_word_t cw;
    kind  = KIND_NONE;
    first = 0;
    n     = 0;
    len   = (stored_st > LEN_MAX) ? LEN_MAX : stored_st;
    // head bytes are only looked at once the count proves they are fresh
    if (stored_st == STATUS_LEN && head_mem[0] == ID_REPORT &&
        head_mem[1] == SUB_STATUS && !busy[0]) begin
      kind  = KIND_STATUS;
      first = 1;
      n     = STATUS_ITEMS;
    end else if (stored_st == TIMING_LEN && head_mem[0] == ID_REPORT &&
                 head_mem[1] == SUB_TIMING && !busy[1]) begin
      kind  = KIND_TIMING;
      first = 1;
      n     = TIMING_ITEMS;
    end else if (stored_st >= SAT_MIN_LEN && head_mem[0] == ID_SAT_LIST &&
                 !busy[2]) begin
      kind  = KIND_SAT;
      first = 0;
      n     = SAT_ITEMS;
    end
    if (n == 0) begin
      // uncaptured close: one bare frame-end word
      cw.kind     = KIND_NONE;
      cw.byte_idx = '0;
      cw.data     = '0;
      cw.length   = len[6:0];
      cw.last     = 1'b1;
      capture_words_due.push_back(cw);
    end else begin
      for (int i = 0; i < n; i++) begin
        cw.kind     = kind;
        cw.byte_idx = i[4:0];
        cw.data     = (first + i < HEAD_DEPTH) ? head_mem[first + i] : 8'h00;
        cw.length   = len[6:0];
        cw.last     = (i == n - 1);
        capture_words_due.push_back(cw);
      end
    end
  endtask

  task automatic deframe_word(rx_word_t w);
    // a line error drops back to hunting before the byte is looked at
    if (w.line_error)
      hunt_st = 1'b1;
    if (hunt_st) begin
      if (w.rx_byte == START_BYTE) begin
        hunt_st   = 1'b0;
        escape_st = 1'b0;
        stored_st = 0;
      end
    end else if (escape_st && w.rx_byte == END_BYTE) begin
      queue_capture(w.slot_busy);
      hunt_st   = 1'b1;
      escape_st = 1'b0;
    end else if (!escape_st && w.rx_byte == START_BYTE) begin
      escape_st = 1'b1;
    end else begin
      // plain byte, doubled start byte or escape followed by a plain byte: store it
      escape_st = 1'b0;
      if (stored_st < BUF_BYTES) begin
        if (stored_st < HEAD_DEPTH)
          head_mem[stored_st] = w.rx_byte;
        stored_st++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: offers one pending word at a time, idles a drawn number of
  // cycles after each accepted word, holds the payload while stalled
  // --------------------------------------------------------------------------
  int   in_gap_left = 0;
  logic in_idle_on  = 1'b1;

  always @(posedge clk) begin
    rx_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_word({in_rx_byte, in_line_error, in_slot_busy});
        in_gap_left = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        // flip between idling and back-to-back stretches now and then
        if ($urandom_range(0, 31) == 0)
          in_idle_on = !in_idle_on;
      end
      if (in_valid && in_stall) begin
        // stalled: word and valid stay as they are
      end else if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (rx_words_pending.size() > 0) begin
        w = rx_words_pending.pop_front();
        in_rx_byte    <= w.rx_byte;
        in_line_error <= w.line_error;
        in_slot_busy  <= w.slot_busy;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks every accepted capture word against the oldest one due,
  // then stalls a drawn number of cycles; a hold request stalls for a long
  // stretch counted here
  // --------------------------------------------------------------------------
  int   out_stall_left = 0;
  int   hold_left      = 0;
  logic out_idle_on    = 1'b1;

  always @(posedge clk) begin
    capture_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (capture_words_due.size() == 0) begin
          report_mismatch("capture word with none due, byte_index",
                          int'(out_byte_index), -1);
        end else begin
          want = capture_words_due.pop_front();
          if (out_frame_kind != want.kind)
            report_mismatch("frame_kind", int'(out_frame_kind), int'(want.kind));
          if (out_byte_index != want.byte_idx)
            report_mismatch("byte_index", int'(out_byte_index), int'(want.byte_idx));
          if (out_data_byte != want.data)
            report_mismatch("data_byte", int'(out_data_byte), int'(want.data));
          if (out_frame_length != want.length)
            report_mismatch("frame_length", int'(out_frame_length), int'(want.length));
          if (out_last != want.last)
            report_mismatch("last", int'(out_last), int'(want.last));
        end
        out_stall_left = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if ($urandom_range(0, 31) == 0)
          out_idle_on = !out_idle_on;
      end
      if (hold_reqs != holds_taken) begin
        holds_taken = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too many cycles without a word moving on either side
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("** dle_framed_packet_capture_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers, all called at the falling edge
  // --------------------------------------------------------------------------
  task automatic push_word(logic [7:0] b, logic err);
    rx_word_t w;
    w.rx_byte    = b;
    w.line_error = err;
    w.slot_busy  = 3'($urandom_range(0, 7));  // busy mask only matters at close
    rx_words_pending.push_back(w);
    words_pushed++;
  endtask

  // payload with chosen first two bytes, rest random with extra start/end bytes
  function automatic body_q_t make_body(int n, logic [7:0] b0, logic [7:0] b1);
    body_q_t body;
    int      r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (i == 0)
        body.push_back(b0);
      else if (i == 1)
        body.push_back(b1);
      else if (r < 2)
        body.push_back(START_BYTE);
      else if (r == 2)
        body.push_back(END_BYTE);
      else
        body.push_back(8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  // stuffed frame: start, payload with doubled start bytes, escape + end
  // lone_pct: chance of a lone escape ahead of a plain byte
  // err_pct: chance of a line error on the word carrying each payload byte
  task automatic push_frame(body_q_t body, logic [2:0] busy, int lone_pct, int err_pct);
    rx_word_t w;
    push_word(START_BYTE, 1'b0);
    foreach (body[i]) begin
      if (body[i] == START_BYTE) begin
        push_word(START_BYTE, $urandom_range(0, 99) < err_pct);
        push_word(START_BYTE, 1'b0);
      end else begin
        if (body[i] != END_BYTE && $urandom_range(0, 99) < lone_pct)
          push_word(START_BYTE, 1'b0);
        push_word(body[i], $urandom_range(0, 99) < err_pct);
      end
    end
    push_word(START_BYTE, 1'b0);
    w.rx_byte    = END_BYTE;
    w.line_error = 1'b0;
    w.slot_busy  = busy;
    rx_words_pending.push_back(w);
    words_pushed++;
  endtask

  // sender pause: everything offered and every capture word out
  task automatic wait_quiet();
    while (rx_words_pending.size() != 0 || in_valid || capture_words_due.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int       r;
    int       n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [2:0] busy;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    // noise while hunting, one word with a line error
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b1);
    push_word(END_BYTE, 1'b0);
    // status frame first with its slot busy: it fills the whole head store
    // and closes uncaptured
    push_frame(make_body(STATUS_LEN, ID_REPORT, SUB_STATUS), SLOT_STATUS, 0, 0);
    push_frame(make_body(TIMING_LEN, ID_REPORT, SUB_TIMING), 3'b101, 0, 0);
    push_frame(make_body(SAT_MIN_LEN, ID_SAT_LIST, 8'hff), 3'b011, 0, 0);
    // busy slots: timing and satellite frames close uncaptured
    push_frame(make_body(TIMING_LEN, ID_REPORT, SUB_TIMING), SLOT_TIMING, 0, 0);
    push_frame(make_body(5, ID_SAT_LIST, 8'h00), SLOT_SAT, 0, 0);
    // short frames: empty, and a satellite list one byte short
    push_frame(make_body(0, 8'h00, 8'h00), SLOTS_FREE, 0, 0);
    push_frame(make_body(SAT_MIN_LEN - 1, ID_SAT_LIST, 8'h12), SLOTS_FREE, 0, 0);
    // wrong lengths for timing, and length overflow that saturates to status
    push_frame(make_body(TIMING_LEN + 1, ID_REPORT, SUB_TIMING), SLOTS_FREE, 0, 0);
    push_frame(make_body(75, ID_REPORT, SUB_STATUS), SLOTS_FREE, 0, 0);
    // escape followed by a plain byte for every payload byte but start and end bytes
    push_frame(make_body(8, ID_SAT_LIST, 8'h7f), SLOTS_FREE, 100, 0);
    // line error mid frame on a start byte: the same byte opens a new frame
    push_word(START_BYTE, 1'b0);
    push_word(ID_SAT_LIST, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(START_BYTE, 1'b1);
    push_frame(make_body(4, ID_SAT_LIST, 8'h22), SLOTS_FREE, 0, 0);
    // line error on the closing byte: no close, the next end byte is ignored
    push_word(START_BYTE, 1'b0);
    push_word(ID_SAT_LIST, 1'b0);
    push_word(8'h55, 1'b0);
    push_word(8'haa, 1'b0);
    push_word(START_BYTE, 1'b0);
    push_word(END_BYTE, 1'b1);
    push_word(END_BYTE, 1'b0);
    wait_quiet();

    // long hold-off on the output while short capture frames keep coming,
    // so the descriptor queue fills and the input stalls
    hold_reqs++;
    for (int i = 0; i < HOLD_FRAMES; i++)
      push_frame(make_body(int'($urandom_range(3, 5)), ID_SAT_LIST,
                           8'($urandom_range(0, 255))),
                 SLOTS_FREE, 0, 0);
    wait_quiet();

    // random part: mostly well-formed frames with random content,
    // plus noise and broken frames, up to the word budget
    while (words_pushed < TOTAL_WORDS) begin
      r    = $urandom_range(0, 99);
      busy = ($urandom_range(0, 1) == 0) ? SLOTS_FREE : 3'($urandom_range(0, 7));
      b1   = 8'($urandom_range(0, 255));
      if (r < 30) begin
        n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        b0 = ID_SAT_LIST;
      end else if (r < 50) begin
        n  = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 20) : TIMING_LEN;
        b0 = ID_REPORT;
        b1 = ($urandom_range(0, 5) == 0) ? SUB_STATUS : SUB_TIMING;
      end else if (r < 55) begin
        n  = ($urandom_range(0, 3) == 0) ? $urandom_range(66, 100) : STATUS_LEN;
        b0 = ID_REPORT;
        b1 = ($urandom_range(0, 5) == 0) ? SUB_TIMING : SUB_STATUS;
      end else if (r < 80) begin
        n = $urandom_range(0, 24);
        case ($urandom_range(0, 2))
          0: b0 = ID_REPORT;
          1: b0 = ID_SAT_LIST;
          default: b0 = 8'($urandom_range(0, 255));
        endcase
      end else begin
        n = -1;
      end
      if (n < 0) begin
        // noise between frames
        repeat ($urandom_range(1, 6))
          push_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end else begin
        push_frame(make_body(n, b0, b1), busy, $urandom_range(0, 1) * 10,
                   ($urandom_range(0, 9) == 0) ? 5 : 0);
      end
    end
    wait_quiet();

    // let any stray word show up before the verdict
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && capture_words_due.size() == 0) begin
      $display("** dle_framed_packet_capture_top: PASSED **");
    end else begin
      $display("** dle_framed_packet_capture_top: FAILED **");
    end
    $finish;
  end

endmodule
